/* hw/rtl/fcl_pkg.sv */
// ----------------------------------------------------------------------------
// FAT16 cluster chain locator package
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package fcl_pkg;

  localparam int TABLE_DEPTH_DEF  = 65536;
  localparam int SECTOR_BYTES_DEF = 512;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Links at or above this value terminate a chain.
  localparam logic [15:0] END_MARK = 16'hFFF8;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_LOCATE = 2'd1,
    OP_COUNT  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_END   = 2'd1,
    ST_RANGE = 2'd2,
    ST_LONG  = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CLUSTER_BYTES = 2'd0,
    CFG_DATA_BASE     = 2'd1,
    CFG_ROOT_BASE     = 2'd2,
    CFG_TABLE_ENTRIES = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_FIN
  } ctrl_state_t;

  typedef enum logic [1:0] {
    RES_IMM,
    RES_WALK,
    RES_LOC
  } res_sel_t;

  typedef struct packed {
    logic     start;
    logic     step;
    logic     mul_en;
    logic     out_load;
    res_sel_t res_sel;
  } ctl_t;

  typedef struct packed {
    logic is_walk;
    logic walk_done;
    logic walk_to_mul;
  } sts_t;

endpackage

/* hw/rtl/fcl_cmd_if.sv */
// ----------------------------------------------------------------------------
// Command channel
// Valid/ready channel carrying one request item.
// ----------------------------------------------------------------------------
interface fcl_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [15:0] cluster;
  logic [15:0] entry_value;
  logic [31:0] byte_offset;

  modport source (output valid, opcode, cluster, entry_value, byte_offset, input ready);
  modport sink (input valid, opcode, cluster, entry_value, byte_offset, output ready);
endinterface

/* hw/rtl/fcl_res_if.sv */
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
interface fcl_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] cluster_found;
  logic [31:0] first_sector;
  logic [15:0] byte_within;
  logic [16:0] chain_length;

  modport source (output valid, status, cluster_found, first_sector, byte_within,
                  chain_length, input ready);
  modport sink (input valid, status, cluster_found, first_sector, byte_within,
                chain_length, output ready);
endinterface

/* hw/rtl/fcl_datapath.sv */
// ----------------------------------------------------------------------------
// FAT16 locator datapath
// Configuration registers, link table memory, walk registers and result register.
// ----------------------------------------------------------------------------
module fcl_datapath #(
  parameter int TABLE_DEPTH  = fcl_pkg::TABLE_DEPTH_DEF,
  parameter int SECTOR_BYTES = fcl_pkg::SECTOR_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [fcl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fcl_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [1:0]                    opcode,
  input  logic [15:0]                   cluster,
  input  logic [15:0]                   entry_value,
  input  logic [31:0]                   byte_offset,
  input  fcl_pkg::ctl_t                 ctl,
  output fcl_pkg::sts_t                 sts,
  output logic [1:0]                    status,
  output logic [15:0]                   cluster_found,
  output logic [31:0]                   first_sector,
  output logic [15:0]                   byte_within,
  output logic [16:0]                   chain_length
);

  localparam int          IDX_W    = $clog2(TABLE_DEPTH);
  localparam int          SEC_SH   = $clog2(SECTOR_BYTES);
  localparam logic [16:0] DEPTH_17 = 17'(TABLE_DEPTH);

  // Configuration registers.
  logic [16:0] cluster_bytes;
  logic [31:0] data_base;
  logic [31:0] root_base;
  logic [16:0] table_entries;

  always_ff @(posedge clk) begin
    if (rst) begin
      cluster_bytes <= 17'd2048;
      data_base     <= 32'd0;
      root_base     <= 32'd0;
      table_entries <= 17'd65536;
    end else if (cfg_we) begin
      case (cfg_index)
        fcl_pkg::CFG_CLUSTER_BYTES: cluster_bytes <= cfg_data[16:0];
        fcl_pkg::CFG_DATA_BASE:     data_base     <= cfg_data;
        fcl_pkg::CFG_ROOT_BASE:     root_base     <= cfg_data;
        fcl_pkg::CFG_TABLE_ENTRIES: table_entries <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  logic [16:0] lim;
  assign lim = (table_entries > DEPTH_17) ? DEPTH_17 : table_entries;

  // Walk registers.
  logic [15:0] cur;
  logic [15:0] cur_next;
  logic [31:0] off;
  logic [16:0] walked;
  logic [15:0] last;
  logic        count_mode;
  logic [31:0] prod;

  // Link table.
  logic [15:0]      link_table [TABLE_DEPTH];
  logic [15:0]      rd_data;
  logic [IDX_W-1:0] rd_addr;
  logic             load_in_range;
  logic             tbl_we;

  assign load_in_range = {1'b0, cluster} < DEPTH_17;
  assign tbl_we        = ctl.start && (opcode == fcl_pkg::OP_LOAD) && load_in_range;

  always_comb begin
    if (ctl.start) begin
      cur_next = cluster;
    end else if (ctl.step) begin
      cur_next = rd_data;
    end else begin
      cur_next = cur;
    end
  end

  // The read address follows the next current cluster, so the read data,
  // registered on the same edge as cur, holds the link of the current cluster.
  assign rd_addr = cur_next[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      link_table[cluster[IDX_W-1:0]] <= entry_value;
    end
    rd_data <= link_table[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur        <= 16'd0;
      off        <= 32'd0;
      walked     <= 17'd0;
      last       <= 16'd0;
      count_mode <= 1'b0;
    end else if (ctl.start) begin
      cur        <= cur_next;
      off        <= byte_offset;
      walked     <= 17'd0;
      last       <= cluster;
      count_mode <= (opcode == fcl_pkg::OP_COUNT);
    end else if (ctl.step) begin
      cur    <= cur_next;
      off    <= off - {15'd0, cluster_bytes};
      walked <= walked + 17'd1;
      last   <= cur;
    end
  end

  // A 16-bit cluster times a 17-bit cluster size can need 33 bits; only the low 32 bits are kept.
  logic [31:0] prod_full;
  assign prod_full = {16'd0, cur - 16'd2} * {15'd0, cluster_bytes};

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod <= prod_full;
    end
  end

  // Checks made before a link is followed.
  logic              cur_end;
  logic              cur_big;
  logic              need_link;
  fcl_pkg::status_t  chk;
  fcl_pkg::status_t  walk_status;

  assign cur_end   = (cur == 16'd0) || (cur >= fcl_pkg::END_MARK);
  assign cur_big   = {1'b0, cur} >= lim;
  assign need_link = off >= {15'd0, cluster_bytes};

  always_comb begin
    if (cur_end) begin
      chk = fcl_pkg::ST_END;
    end else if (cur_big) begin
      chk = fcl_pkg::ST_RANGE;
    end else if (walked >= lim) begin
      chk = fcl_pkg::ST_LONG;
    end else begin
      chk = fcl_pkg::ST_OK;
    end
  end

  always_comb begin
    sts.is_walk     = ((opcode == fcl_pkg::OP_LOCATE) && (cluster != 16'd0)) ||
                      (opcode == fcl_pkg::OP_COUNT);
    sts.walk_done   = 1'b0;
    sts.walk_to_mul = 1'b0;
    walk_status     = fcl_pkg::ST_OK;
    if (count_mode) begin
      // A count ends normally on an end or free marker.
      if (chk == fcl_pkg::ST_END) begin
        sts.walk_done = 1'b1;
      end else if (chk != fcl_pkg::ST_OK) begin
        sts.walk_done = 1'b1;
        walk_status   = chk;
      end
    end else if (need_link) begin
      if (chk != fcl_pkg::ST_OK) begin
        sts.walk_done = 1'b1;
        walk_status   = chk;
      end
    end else begin
      // Final cluster of a locate; cluster 1 has no data region.
      sts.walk_done = 1'b1;
      if (cur_end) begin
        walk_status = fcl_pkg::ST_END;
      end else if (cur_big || (cur == 16'd1)) begin
        walk_status = fcl_pkg::ST_RANGE;
      end else begin
        sts.walk_to_mul = 1'b1;
      end
    end
  end

  // Results that need no walk.
  logic [31:0]      root_addr;
  logic [31:0]      loc_addr;
  fcl_pkg::status_t imm_status;
  logic [15:0]      imm_found;
  logic [31:0]      imm_sector;
  logic [15:0]      imm_within;

  assign root_addr = root_base + byte_offset;
  assign loc_addr  = data_base + prod;

  always_comb begin
    imm_status = fcl_pkg::ST_OK;
    imm_found  = 16'd0;
    imm_sector = 32'd0;
    imm_within = 16'd0;
    case (opcode)
      fcl_pkg::OP_LOAD: begin
        if (load_in_range) begin
          imm_found = cluster;
        end else begin
          imm_status = fcl_pkg::ST_RANGE;
        end
      end
      fcl_pkg::OP_LOCATE: begin
        imm_sector = root_addr >> SEC_SH;
        imm_within = 16'(root_addr[SEC_SH-1:0]);
      end
      default: ;
    endcase
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      case (ctl.res_sel)
        fcl_pkg::RES_IMM: begin
          status        <= imm_status;
          cluster_found <= imm_found;
          first_sector  <= imm_sector;
          byte_within   <= imm_within;
          chain_length  <= 17'd0;
        end
        fcl_pkg::RES_WALK: begin
          status        <= walk_status;
          cluster_found <= count_mode ? last : cur;
          first_sector  <= 32'd0;
          byte_within   <= 16'd0;
          chain_length  <= count_mode ? walked : 17'd0;
        end
        fcl_pkg::RES_LOC: begin
          status        <= fcl_pkg::ST_OK;
          cluster_found <= cur;
          first_sector  <= loc_addr >> SEC_SH;
          byte_within   <= off[15:0];
          chain_length  <= 17'd0;
        end
        default: begin
          status        <= fcl_pkg::ST_OK;
          cluster_found <= 16'd0;
          first_sector  <= 32'd0;
          byte_within   <= 16'd0;
          chain_length  <= 17'd0;
        end
      endcase
    end
  end

endmodule

/* hw/rtl/fcl_ctrl.sv */
// ----------------------------------------------------------------------------
// FAT16 locator controller
// Sequences one request at a time and owns the result valid flag.
// ----------------------------------------------------------------------------
module fcl_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  fcl_pkg::sts_t sts,
  output fcl_pkg::ctl_t ctl
);

  fcl_pkg::ctrl_state_t state;
  fcl_pkg::ctrl_state_t state_next;
  logic                 out_free;
  logic                 accept;

  // The result register may be refilled in the same cycle its item transfers.
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == fcl_pkg::S_IDLE) && out_free;
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next = state;
    case (state)
      fcl_pkg::S_IDLE: begin
        if (accept && sts.is_walk) begin
          state_next = fcl_pkg::S_WALK;
        end
      end
      fcl_pkg::S_WALK: begin
        if (sts.walk_done && sts.walk_to_mul) begin
          state_next = fcl_pkg::S_FIN;
        end else if (sts.walk_done && out_free) begin
          state_next = fcl_pkg::S_IDLE;
        end
      end
      fcl_pkg::S_FIN: begin
        if (out_free) begin
          state_next = fcl_pkg::S_IDLE;
        end
      end
      default: state_next = fcl_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ctl.start    = 1'b0;
    ctl.step     = 1'b0;
    ctl.mul_en   = 1'b0;
    ctl.out_load = 1'b0;
    ctl.res_sel  = fcl_pkg::RES_IMM;
    case (state)
      fcl_pkg::S_IDLE: begin
        ctl.start    = accept;
        ctl.out_load = accept && !sts.is_walk;
      end
      fcl_pkg::S_WALK: begin
        ctl.step     = !sts.walk_done;
        ctl.mul_en   = sts.walk_done && sts.walk_to_mul;
        ctl.out_load = sts.walk_done && !sts.walk_to_mul && out_free;
        ctl.res_sel  = fcl_pkg::RES_WALK;
      end
      fcl_pkg::S_FIN: begin
        ctl.out_load = out_free;
        ctl.res_sel  = fcl_pkg::RES_LOC;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= fcl_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* hw/rtl/fat16_cluster_chain_locator_top.sv */
// ----------------------------------------------------------------------------
// FAT16 cluster chain locator
// Holds a FAT16 link table; loads entries, locates byte offsets, counts chains.
//
//   Channel  Dir  Carries
//   cmd      in   opcode, cluster, entry_value, byte_offset
//   res      out  status, cluster_found, first_sector, byte_within, chain_length
//   cfg      in   cfg_we, cfg_index, cfg_data (write only)
//
// Loads, root locates and unknown opcodes are answered at their accepting
// edge, so they can follow one per cycle while results are taken. A walk
// reads the table once per link followed, and a successful locate then
// passes through S_FIN for the sector multiply; cmd is held off meanwhile.
// A result that has not transferred also holds off cmd. The table is not
// cleared by reset and reads are only meaningful for entries already loaded.
// ----------------------------------------------------------------------------
module fat16_cluster_chain_locator_top #(
  parameter int TABLE_DEPTH  = fcl_pkg::TABLE_DEPTH_DEF,
  parameter int SECTOR_BYTES = fcl_pkg::SECTOR_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  fcl_cmd_if.sink                       cmd,
  fcl_res_if.source                     res,
  input  logic                          cfg_we,
  input  logic [fcl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fcl_pkg::CFG_DATA_W-1:0] cfg_data
);

  fcl_pkg::ctl_t ctl;
  fcl_pkg::sts_t sts;
  logic          cmd_ready;
  logic          res_valid;
  logic [1:0]    res_status;
  logic [15:0]   res_cluster_found;
  logic [31:0]   res_first_sector;
  logic [15:0]   res_byte_within;
  logic [16:0]   res_chain_length;

  fcl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cmd.valid),
    .in_ready  (cmd_ready),
    .out_valid (res_valid),
    .out_ready (res.ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  fcl_datapath #(
    .TABLE_DEPTH  (TABLE_DEPTH),
    .SECTOR_BYTES (SECTOR_BYTES)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .opcode        (cmd.opcode),
    .cluster       (cmd.cluster),
    .entry_value   (cmd.entry_value),
    .byte_offset   (cmd.byte_offset),
    .ctl           (ctl),
    .sts           (sts),
    .status        (res_status),
    .cluster_found (res_cluster_found),
    .first_sector  (res_first_sector),
    .byte_within   (res_byte_within),
    .chain_length  (res_chain_length)
  );

  assign cmd.ready         = cmd_ready;
  assign res.valid         = res_valid;
  assign res.status        = res_status;
  assign res.cluster_found = res_cluster_found;
  assign res.first_sector  = res_first_sector;
  assign res.byte_within   = res_byte_within;
  assign res.chain_length  = res_chain_length;

endmodule

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// FAT16 cluster chain locator testbench
// Drives table loads, locates and chain counts through the command channel. A
// built-in model of the link table predicts each result, and each result is
// compared field by field in arrival order. The run covers directed corner
// cases, runaway and out-of-table walks, and random chain traffic under
// several register settings. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;

  localparam logic [1:0]  OP_UNUSED   = 2'd3;
  localparam logic [31:0] SECTOR      = 32'(fcl_pkg::SECTOR_BYTES_DEF);
  localparam int unsigned DEPTH       = fcl_pkg::TABLE_DEPTH_DEF;
  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int unsigned WALK_CAP    = 200;
  localparam int unsigned NO_CAP      = 200_000;

  typedef enum int {TAIL_ANY, TAIL_END, TAIL_ZERO, TAIL_RANGE, TAIL_ONE, TAIL_LOOP} tail_t;

  typedef struct {
    fcl_pkg::status_t status;
    logic [15:0]      cluster_found;
    logic [31:0]      first_sector;
    logic [15:0]      byte_within;
    logic [16:0]      chain_length;
  } answer_t;

  typedef struct {
    fcl_pkg::status_t st;
    int unsigned      cur;
    int unsigned      last;
    int unsigned      n;
    logic [31:0]      off;
    int               hole;
  } walk_t;

  logic                           clk;
  logic                           rst;
  logic                           cfg_we;
  logic [fcl_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [fcl_pkg::CFG_DATA_W-1:0] cfg_data;

  fcl_cmd_if cmd_ch ();
  fcl_res_if res_ch ();

  fat16_cluster_chain_locator_top u_top (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_ch),
    .res       (res_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Mirror of the link table and the registers.
  logic [15:0] link_mirror [DEPTH];
  bit          link_known  [DEPTH];
  logic [16:0] cluster_bytes;
  logic [31:0] data_base;
  logic [31:0] root_base;
  logic [16:0] table_entries;

  answer_t     pending_answers [$];
  logic [15:0] chain_nodes [$];

  int unsigned burst_left;
  int unsigned items_sent, loads_sent, locates_sent, counts_sent, unused_sent;
  int unsigned results_checked, long_walks, range_stops, cycles;
  int          failures;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("testbench NOT OK");
    $finish;
  end

  function automatic int unsigned table_limit();
    return (table_entries > DEPTH) ? DEPTH : int'(table_entries);
  endfunction

  // Highest cluster that can sit inside a chain: below the limit and no end marker.
  function automatic int unsigned top_cluster();
    int unsigned top;
    top = table_limit() - 1;
    return (top > 32'hFFF7) ? 32'hFFF7 : top;
  endfunction

  function automatic fcl_pkg::status_t link_check(int unsigned c, int unsigned walked,
                                                  int unsigned lim);
    if (c == 0 || c >= fcl_pkg::END_MARK) return fcl_pkg::ST_END;
    if (c >= lim) return fcl_pkg::ST_RANGE;
    if (walked >= lim) return fcl_pkg::ST_LONG;
    return fcl_pkg::ST_OK;
  endfunction

  // Follows a chain through the mirror. Stops early at the first entry that
  // was never loaded and reports it as a hole.
  function automatic walk_t trace_chain(logic [1:0] op, int unsigned start,
                                        logic [31:0] boff);
    walk_t            w;
    int unsigned      lim;
    fcl_pkg::status_t s;
    lim    = table_limit();
    w.st   = fcl_pkg::ST_OK;
    w.cur  = start;
    w.last = start;
    w.off  = boff;
    w.n    = 0;
    w.hole = -1;
    if (op == fcl_pkg::OP_LOCATE) begin
      while (w.off >= cluster_bytes) begin
        s = link_check(w.cur, w.n, lim);
        if (s != fcl_pkg::ST_OK) begin
          w.st = s;
          break;
        end
        if (!link_known[w.cur]) begin
          w.hole = int'(w.cur);
          return w;
        end
        w.cur = link_mirror[w.cur];
        w.off = w.off - 32'(cluster_bytes);
        w.n++;
      end
      if (w.st == fcl_pkg::ST_OK) begin
        if (w.cur == 0 || w.cur >= fcl_pkg::END_MARK) w.st = fcl_pkg::ST_END;
        else if (w.cur >= lim || w.cur == 1) w.st = fcl_pkg::ST_RANGE;
      end
    end else begin
      while (1) begin
        s = link_check(w.cur, w.n, lim);
        if (s == fcl_pkg::ST_END) break;
        if (s != fcl_pkg::ST_OK) begin
          w.st = s;
          break;
        end
        if (!link_known[w.cur]) begin
          w.hole = int'(w.cur);
          return w;
        end
        w.last = w.cur;
        w.cur  = link_mirror[w.cur];
        w.n++;
      end
    end
    return w;
  endfunction

  function automatic answer_t predict_answer(logic [1:0] op, logic [15:0] cl,
                                             logic [15:0] val, logic [31:0] off);
    answer_t     a;
    walk_t       w;
    logic [31:0] addr;
    a.status        = fcl_pkg::ST_OK;
    a.cluster_found = '0;
    a.first_sector  = '0;
    a.byte_within   = '0;
    a.chain_length  = '0;
    case (op)
      fcl_pkg::OP_LOAD: begin
        link_mirror[cl]  = val;
        link_known[cl]   = 1'b1;
        a.cluster_found  = cl;
      end
      fcl_pkg::OP_LOCATE: begin
        if (cl == 16'd0) begin
          addr           = root_base + off;
          a.first_sector = addr / SECTOR;
          a.byte_within  = 16'(addr % SECTOR);
        end else begin
          w               = trace_chain(op, cl, off);
          a.status        = w.st;
          a.cluster_found = 16'(w.cur);
          if (w.st == fcl_pkg::ST_OK) begin
            addr           = data_base + (32'(w.cur) - 32'd2) * 32'(cluster_bytes);
            a.first_sector = addr / SECTOR;
            a.byte_within  = w.off[15:0];
          end
        end
      end
      fcl_pkg::OP_COUNT: begin
        w               = trace_chain(op, cl, off);
        a.status        = w.st;
        a.cluster_found = 16'(w.last);
        a.chain_length  = 17'(w.n);
      end
      default: ;
    endcase
    return a;
  endfunction

  // Link value for a fresh entry: mostly end or free markers, so random walks stay short.
  function automatic logic [15:0] pick_link();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 45) return fcl_pkg::END_MARK | 16'($urandom_range(7));
    if (r < 55) return 16'd0;
    if (r < 90) return 16'($urandom_range(top_cluster(), 2));
    return 16'($urandom);
  endfunction

  function automatic bit field_ok(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic send_item(logic [1:0] op, logic [15:0] cl, logic [15:0] val,
                           logic [31:0] off);
    if (burst_left == 0) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
      burst_left = ($urandom_range(3) == 0) ? $urandom_range(120, 40) : $urandom_range(12, 1);
    end
    burst_left--;
    pending_answers.push_back(predict_answer(op, cl, val, off));
    items_sent++;
    case (op)
      fcl_pkg::OP_LOAD:   loads_sent++;
      fcl_pkg::OP_LOCATE: locates_sent++;
      fcl_pkg::OP_COUNT:  counts_sent++;
      default:            unused_sent++;
    endcase
    cmd_ch.valid       <= 1'b1;
    cmd_ch.opcode      <= op;
    cmd_ch.cluster     <= cl;
    cmd_ch.entry_value <= val;
    cmd_ch.byte_offset <= off;
    do @(posedge clk); while (!cmd_ch.ready);
  endtask

  // Loads any entry the walk would read before it was written, then sends the
  // query unless the walk is longer than allowed.
  task automatic run_query(logic [1:0] op, logic [15:0] cl, logic [31:0] off,
                           int unsigned max_links);
    walk_t w;
    if (op == fcl_pkg::OP_LOCATE && cl == 16'd0) begin
      send_item(op, cl, 16'($urandom), off);
      return;
    end
    w = trace_chain(op, cl, off);
    while (w.hole >= 0) begin
      send_item(fcl_pkg::OP_LOAD, 16'(w.hole), pick_link(), $urandom);
      w = trace_chain(op, cl, off);
    end
    if (w.n <= max_links) send_item(op, cl, 16'($urandom), off);
  endtask

  task automatic wait_idle();
    cmd_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic apply_settings(logic [31:0] cb_word, logic [31:0] db_word,
                                logic [31:0] rb_word, logic [31:0] te_word);
    cfg_we    <= 1'b1;
    cfg_index <= fcl_pkg::CFG_CLUSTER_BYTES;
    cfg_data  <= cb_word;
    @(posedge clk);
    cfg_index <= fcl_pkg::CFG_DATA_BASE;
    cfg_data  <= db_word;
    @(posedge clk);
    cfg_index <= fcl_pkg::CFG_ROOT_BASE;
    cfg_data  <= rb_word;
    @(posedge clk);
    cfg_index <= fcl_pkg::CFG_TABLE_ENTRIES;
    cfg_data  <= te_word;
    @(posedge clk);
    cfg_we <= 1'b0;
    cluster_bytes = cb_word[16:0];
    data_base     = db_word;
    root_base     = rb_word;
    table_entries = te_word[16:0];
  endtask

  // Loads a chain of distinct clusters into the table, ending as asked.
  task automatic build_chain(tail_t kind);
    logic [15:0] node, tail, link;
    int unsigned len, lim;
    bit          dup;
    lim = table_limit();
    chain_nodes.delete();
    len = ($urandom_range(9) == 0) ? $urandom_range(40, 8) : $urandom_range(6, 1);
    while (chain_nodes.size() < len) begin
      node = 16'($urandom_range(top_cluster(), 2));
      dup  = 1'b0;
      foreach (chain_nodes[j]) if (chain_nodes[j] == node) dup = 1'b1;
      if (!dup) chain_nodes.push_back(node);
    end
    if (kind == TAIL_ANY) kind = tail_t'($urandom_range(TAIL_ONE, TAIL_END));
    case (kind)
      TAIL_ZERO:  tail = 16'd0;
      TAIL_RANGE: begin
        if (lim <= 32'hFFF7) tail = 16'($urandom_range(32'hFFF7, lim));
        else tail = fcl_pkg::END_MARK;
      end
      TAIL_ONE:   tail = 16'd1;
      TAIL_LOOP:  tail = chain_nodes[$urandom_range(len - 1)];
      default:    tail = fcl_pkg::END_MARK | 16'($urandom_range(7));
    endcase
    for (int i = 0; i < len; i++) begin
      link = (i + 1 < len) ? chain_nodes[i + 1] : tail;
      send_item(fcl_pkg::OP_LOAD, chain_nodes[i], link, $urandom);
    end
  endtask

  // Counts and locates into the chain just built, with offsets that land near it.
  task automatic probe_chain(int unsigned max_links);
    int unsigned pos, hops;
    logic [31:0] off;
    repeat ($urandom_range(4, 2)) begin
      pos = $urandom_range(chain_nodes.size() - 1);
      if ($urandom_range(2) == 0) begin
        run_query(fcl_pkg::OP_COUNT, chain_nodes[pos], $urandom, max_links);
      end else begin
        hops = $urandom_range(chain_nodes.size() - pos + 1);
        if (cluster_bytes == 0) off = $urandom;
        else off = 32'(hops) * 32'(cluster_bytes) + $urandom_range(32'(cluster_bytes) - 1);
        run_query(fcl_pkg::OP_LOCATE, chain_nodes[pos], off, max_links);
      end
    end
  endtask

  task automatic mixed_traffic(int unsigned quota);
    int unsigned goal, pick;
    logic [15:0] start;
    logic [31:0] off;
    logic [1:0]  op;
    goal = items_sent + quota;
    while (items_sent < goal) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        build_chain(TAIL_ANY);
        probe_chain(WALK_CAP);
      end else if (pick < 62) begin
        run_query(fcl_pkg::OP_LOCATE, 16'd0, $urandom, WALK_CAP);
      end else if (pick < 74) begin
        send_item(fcl_pkg::OP_LOAD, 16'($urandom), pick_link(), $urandom);
      end else if (pick < 95) begin
        case ($urandom_range(9))
          0, 1, 2, 3: start = 16'($urandom_range(15));
          4:          start = 16'($urandom_range(16'hFFFF, 16'hFFF8));
          default:    start = 16'($urandom);
        endcase
        off = $urandom_range(1) ? $urandom : $urandom_range(32'(cluster_bytes) * 4);
        op  = $urandom_range(1) ? fcl_pkg::OP_LOCATE : fcl_pkg::OP_COUNT;
        run_query(op, start, off, WALK_CAP);
      end else begin
        send_item(OP_UNUSED, 16'($urandom), 16'($urandom), $urandom);
      end
    end
  endtask

  // Reset register values: a two-link chain, root locates, empty and marker starts.
  task automatic test_directed_cases();
    send_item(fcl_pkg::OP_LOAD, 16'd0, 16'hFFFF, 32'hFFFF_FFFF);
    send_item(fcl_pkg::OP_LOAD, 16'hFFFF, 16'h0000, 32'h0);
    send_item(fcl_pkg::OP_LOAD, 16'd2, 16'd3, $urandom);
    send_item(fcl_pkg::OP_LOAD, 16'd3, fcl_pkg::END_MARK, $urandom);
    send_item(fcl_pkg::OP_LOAD, 16'd1, 16'hFFFF, $urandom);
    send_item(fcl_pkg::OP_LOCATE, 16'd0, 16'hFFFF, 32'h0);
    send_item(fcl_pkg::OP_LOCATE, 16'd0, 16'h0, 32'hFFFF_FFFF);
    send_item(fcl_pkg::OP_LOCATE, 16'd2, 16'h0, 32'd0);
    send_item(fcl_pkg::OP_LOCATE, 16'd2, 16'h0, 32'd2047);
    send_item(fcl_pkg::OP_LOCATE, 16'd2, 16'h0, 32'd2048);
    send_item(fcl_pkg::OP_LOCATE, 16'd2, 16'h0, 32'd4096);
    send_item(fcl_pkg::OP_COUNT, 16'd2, 16'h0, 32'h0);
    send_item(fcl_pkg::OP_COUNT, 16'd0, 16'h0, 32'h0);
    send_item(fcl_pkg::OP_COUNT, 16'hFFFF, 16'h0, 32'h0);
    send_item(fcl_pkg::OP_COUNT, 16'd1, 16'h0, 32'h0);
    // Cluster 1 has no data region, so it ends a locate as out of table.
    send_item(fcl_pkg::OP_LOCATE, 16'd1, 16'h0, 32'd0);
    send_item(fcl_pkg::OP_LOCATE, 16'hFFFF, 16'h0, 32'd100);
    send_item(OP_UNUSED, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_item(OP_UNUSED, 16'h0, 16'h0, 32'h0);
  endtask

  // Looped chains run into the walk limit; a link past the table stops a walk.
  task automatic test_runaway_walks();
    wait_idle();
    apply_settings(32'd512, $urandom, 32'hFFFF_FFFF, 32'd4096);
    build_chain(TAIL_LOOP);
    run_query(fcl_pkg::OP_COUNT, chain_nodes[0], 32'd0, NO_CAP);
    run_query(fcl_pkg::OP_LOCATE, chain_nodes[0], 32'd3_000_000 + $urandom_range(999), NO_CAP);
    build_chain(TAIL_RANGE);
    run_query(fcl_pkg::OP_COUNT, chain_nodes[0], 32'd0, NO_CAP);
    run_query(fcl_pkg::OP_LOCATE, chain_nodes[0], 32'hFFFF_FFFF, NO_CAP);
    wait_idle();
    // Upper bits are junk: cluster_bytes becomes zero, table_entries 4096.
    apply_settings(32'hABCE_0000, $urandom, $urandom, 32'hFFFE_1000);
    build_chain(TAIL_LOOP);
    run_query(fcl_pkg::OP_LOCATE, chain_nodes[0], $urandom, NO_CAP);
    build_chain(TAIL_END);
    run_query(fcl_pkg::OP_LOCATE, chain_nodes[0], $urandom, NO_CAP);
    wait_idle();
    apply_settings(32'd65536, 32'hFFFF_FFFF, $urandom, 32'd65536);
    build_chain(TAIL_LOOP);
    run_query(fcl_pkg::OP_COUNT, chain_nodes[0], 32'd0, NO_CAP);
  endtask

  task automatic test_random_traffic();
    wait_idle();
    apply_settings(32'd512, $urandom, 32'hFFFF_FFFF, 32'd4096);
    mixed_traffic(300);
    wait_idle();
    apply_settings(32'd65536, 32'hFFFF_FFFF, $urandom, 32'd65536);
    mixed_traffic(300);
    wait_idle();
    apply_settings({15'($urandom), 17'($urandom_range(65536, 512))}, 32'd0, 32'd0,
                   {15'($urandom), 17'($urandom_range(65536, 4096))});
    mixed_traffic(300);
    wait_idle();
    apply_settings(32'd0, $urandom, $urandom, 32'($urandom_range(65536, 4096)));
    mixed_traffic(150);
  endtask

  // Result side: checks every transfer and stalls on a pattern of its own.
  initial begin
    answer_t     want;
    int unsigned stall_mode, mode_left, beat;
    bit          ok;
    res_ch.ready <= 1'b0;
    stall_mode = 0;
    mode_left  = 0;
    beat       = 0;
    forever begin
      @(posedge clk);
      if (!rst && res_ch.valid && res_ch.ready) begin
        results_checked++;
        if (pending_answers.size() == 0) begin
          $error("result transfer with nothing expected");
          failures++;
        end else begin
          want = pending_answers.pop_front();
          if (want.status == fcl_pkg::ST_LONG) long_walks++;
          if (want.status == fcl_pkg::ST_RANGE) range_stops++;
          ok = field_ok("status", 32'(want.status), 32'(res_ch.status));
          ok &= field_ok("cluster_found", 32'(want.cluster_found), 32'(res_ch.cluster_found));
          ok &= field_ok("first_sector", want.first_sector, res_ch.first_sector);
          ok &= field_ok("byte_within", 32'(want.byte_within), 32'(res_ch.byte_within));
          ok &= field_ok("chain_length", 32'(want.chain_length), 32'(res_ch.chain_length));
          if (!ok) failures++;
        end
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(3);
        mode_left  = $urandom_range(80, 10);
      end
      mode_left--;
      beat++;
      case (stall_mode)
        0:       res_ch.ready <= 1'b1;
        1:       res_ch.ready <= ($urandom_range(3) != 0);
        2:       res_ch.ready <= (beat % 4 == 0);
        default: res_ch.ready <= (beat % 16 >= 12);
      endcase
    end
  end

  initial begin
    rst                <= 1'b1;
    cfg_we             <= 1'b0;
    cfg_index          <= fcl_pkg::CFG_CLUSTER_BYTES;
    cfg_data           <= '0;
    cmd_ch.valid       <= 1'b0;
    cmd_ch.opcode      <= fcl_pkg::OP_LOAD;
    cmd_ch.cluster     <= '0;
    cmd_ch.entry_value <= '0;
    cmd_ch.byte_offset <= '0;
    cluster_bytes   = 17'd2048;
    data_base       = '0;
    root_base       = '0;
    table_entries   = 17'h10000;
    burst_left      = 0;
    items_sent      = 0;
    loads_sent      = 0;
    locates_sent    = 0;
    counts_sent     = 0;
    unused_sent     = 0;
    results_checked = 0;
    long_walks      = 0;
    range_stops     = 0;
    failures        = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_runaway_walks();
    test_random_traffic();
    wait_idle();

    $display("Sent %0d requests: %0d loads, %0d locates, %0d counts, %0d unused opcodes.",
             items_sent, loads_sent, locates_sent, counts_sent, unused_sent);
    $display("Checked %0d results over eight register settings; %0d hit the walk limit, %0d %s",
             results_checked, long_walks, range_stops, "left the table.");
    if (failures == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/fcl_pkg.sv
hw/rtl/fcl_cmd_if.sv
hw/rtl/fcl_res_if.sv
hw/rtl/fcl_datapath.sv
hw/rtl/fcl_ctrl.sv
hw/rtl/fat16_cluster_chain_locator_top.sv
tb/sv/testbench.sv
